/* design/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and constants
// Item, result and configuration types, sequencer codes and widths used by
// the ellipsoid collision checker modules.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int COORD_BITS    = 16;
  localparam int HALF_BITS     = 15;
  localparam int SLOT_BITS     = 4;
  localparam int NUM_BITS      = 4;
  localparam int ACT_BITS      = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int EXT_BITS      = 16;  // width of a test denominator

  localparam logic [CFG_IDX_BITS-1:0] REG_SEMI_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEMI_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEMI_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE = 3'd3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_AGENT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] pos_t;
  typedef logic [HALF_BITS-1:0]         half_t;
  typedef logic [EXT_BITS-1:0]          ext_t;

  typedef struct packed {
    logic                 req_type;
    logic [SLOT_BITS-1:0] obstacle_slot;
    pos_t                 pos_x;
    pos_t                 pos_y;
    pos_t                 pos_z;
    half_t                obstacle_half_x;
    half_t                obstacle_half_y;
    half_t                obstacle_half_z;
    logic                 first_of_step;
  } req_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] agent_number;
    logic                hits_agent;
    logic                hits_obstacle;
    logic                step_agent_collision;
    logic                step_obstacle_collision;
    logic                agent_overflow;
  } rsp_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } point_t;

  typedef struct packed {
    point_t c;
    half_t  hx;
    half_t  hy;
    half_t  hz;
  } obst_t;

  typedef struct packed {
    half_t               semi_x;
    half_t               semi_y;
    half_t               semi_z;
    logic [ACT_BITS-1:0] active;
  } cfg_t;

  typedef struct packed {
    logic   start;
    point_t p;
    point_t q;
    ext_t   ax;
    ext_t   ay;
    ext_t   az;
  } test_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } test_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_DONE
  } back_state_t;

  typedef enum logic [4:0] {
    OP_SX, OP_SY, OP_SZ,
    OP_BC, OP_AC, OP_AB,
    OP_BC2, OP_AC2, OP_AB2,
    OP_ABC,
    OP_R_LL, OP_R_LH, OP_R_HH,
    OP_L_X0, OP_L_X1, OP_L_Y0, OP_L_Y1, OP_L_Z0, OP_L_Z1
  } test_op_t;

endpackage

/* design/ecc_if.sv */
// ----------------------------------------------------------------------------
// ecc_if: channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ecc_req_if;
  logic          valid;
  logic          ready;
  ecc_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ecc_rsp_if;
  logic          valid;
  logic          ready;
  ecc_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/ecc_ram.sv */
// ----------------------------------------------------------------------------
// ecc_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/ecc_test.sv */
// ----------------------------------------------------------------------------
// ecc_test: ellipsoid overlap test unit
// Exact test dx^2/A^2 + dy^2/B^2 + dz^2/C^2 < 1 by cross-multiplication,
// sequenced over one shared 32x32 multiplier, one registered product at a time.
// ----------------------------------------------------------------------------
module ecc_test (
  input  logic               clk,
  input  logic               rst,
  input  ecc_pkg::test_req_t treq,
  output ecc_pkg::test_rsp_t trsp
);
  import ecc_pkg::*;

  logic              busy, wb, cmp;
  test_op_t          op;
  logic [15:0]       dx, dy, dz, a, b, c;
  logic [31:0]       sx, sy, sz, bc, ac, ab;
  logic [63:0]       bc2, ac2, ab2;
  logic [47:0]       abc;
  logic [97:0]       lhs;
  logic [95:0]       rhs;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [16:0]       ddx, ddy, ddz;
  logic              done, hit;

  assign ddx = {treq.p.x[15], treq.p.x} - {treq.q.x[15], treq.q.x};
  assign ddy = {treq.p.y[15], treq.p.y} - {treq.q.y[15], treq.q.y};
  assign ddz = {treq.p.z[15], treq.p.z} - {treq.q.z[15], treq.q.z};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_SX:   begin mul_a = 32'(dx);  mul_b = 32'(dx); end
      OP_SY:   begin mul_a = 32'(dy);  mul_b = 32'(dy); end
      OP_SZ:   begin mul_a = 32'(dz);  mul_b = 32'(dz); end
      OP_BC:   begin mul_a = 32'(b);   mul_b = 32'(c); end
      OP_AC:   begin mul_a = 32'(a);   mul_b = 32'(c); end
      OP_AB:   begin mul_a = 32'(a);   mul_b = 32'(b); end
      OP_BC2:  begin mul_a = bc;       mul_b = bc; end
      OP_AC2:  begin mul_a = ac;       mul_b = ac; end
      OP_AB2:  begin mul_a = ab;       mul_b = ab; end
      OP_ABC:  begin mul_a = ab;       mul_b = 32'(c); end
      OP_R_LL: begin mul_a = abc[31:0]; mul_b = abc[31:0]; end
      OP_R_LH: begin mul_a = abc[31:0]; mul_b = 32'(abc[47:32]); end
      OP_R_HH: begin mul_a = 32'(abc[47:32]); mul_b = 32'(abc[47:32]); end
      OP_L_X0: begin mul_a = sx;       mul_b = bc2[31:0]; end
      OP_L_X1: begin mul_a = sx;       mul_b = bc2[63:32]; end
      OP_L_Y0: begin mul_a = sy;       mul_b = ac2[31:0]; end
      OP_L_Y1: begin mul_a = sy;       mul_b = ac2[63:32]; end
      OP_L_Z0: begin mul_a = sz;       mul_b = ab2[31:0]; end
      OP_L_Z1: begin mul_a = sz;       mul_b = ab2[63:32]; end
      default: begin mul_a = '0;       mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      wb   <= 1'b0;
      cmp  <= 1'b0;
      done <= 1'b0;
      op   <= OP_SX;
    end else begin
      done <= 1'b0;
      if (treq.start) begin
        dx   <= ddx[16] ? 16'(-ddx) : ddx[15:0];
        dy   <= ddy[16] ? 16'(-ddy) : ddy[15:0];
        dz   <= ddz[16] ? 16'(-ddz) : ddz[15:0];
        a    <= treq.ax;
        b    <= treq.ay;
        c    <= treq.az;
        busy <= 1'b1;
        wb   <= 1'b0;
        op   <= OP_SX;
      end else if (cmp) begin
        hit  <= lhs < 98'(rhs);
        done <= 1'b1;
        cmp  <= 1'b0;
      end else if (busy && !wb) begin
        prod <= 64'(mul_a) * 64'(mul_b);
        wb   <= 1'b1;
      end else if (busy) begin
        wb <= 1'b0;
        case (op)
          OP_SX:   sx  <= prod[31:0];
          OP_SY:   sy  <= prod[31:0];
          OP_SZ:   sz  <= prod[31:0];
          OP_BC:   bc  <= prod[31:0];
          OP_AC:   ac  <= prod[31:0];
          OP_AB:   ab  <= prod[31:0];
          OP_BC2:  bc2 <= prod;
          OP_AC2:  ac2 <= prod;
          OP_AB2:  ab2 <= prod;
          OP_ABC:  abc <= prod[47:0];
          OP_R_LL: rhs <= 96'(prod);
          // cross term appears twice, hence one extra shift
          OP_R_LH: rhs <= rhs + (96'(prod) << 33);
          OP_R_HH: rhs <= rhs + (96'(prod) << 64);
          OP_L_X0: lhs <= 98'(prod);
          OP_L_X1: lhs <= lhs + (98'(prod) << 32);
          OP_L_Y0: lhs <= lhs + 98'(prod);
          OP_L_Y1: lhs <= lhs + (98'(prod) << 32);
          OP_L_Z0: lhs <= lhs + 98'(prod);
          OP_L_Z1: lhs <= lhs + (98'(prod) << 32);
          default: ;
        endcase
        if (op == OP_L_Z1) begin
          busy <= 1'b0;
          cmp  <= 1'b1;
        end else begin
          op <= test_op_t'(op + 5'd1);
        end
      end
    end
  end

  assign trsp.done = done;
  assign trsp.hit  = hit;
endmodule

/* design/ecc_front.sv */
// ----------------------------------------------------------------------------
// ecc_front: request intake
// Takes request transactions, drops loads aimed beyond the obstacle table and
// pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module ecc_front #(
  parameter int MAX_OBSTACLES = 16
) (
  ecc_req_if.sink         req,
  input  logic            full,
  output logic            push,
  output ecc_pkg::req_t   push_data
);
  import ecc_pkg::*;

  logic slot_ok;

  assign slot_ok   = 8'(req.data.obstacle_slot) < 8'(MAX_OBSTACLES);
  assign req.ready = !full;
  assign push      = req.valid && !full && (req.data.req_type == REQ_AGENT || slot_ok);
  assign push_data = req.data;
endmodule

/* design/ecc_queue.sv */
// ----------------------------------------------------------------------------
// ecc_queue: command queue
// Two-entry FIFO between intake and execution.
// ----------------------------------------------------------------------------
module ecc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ecc_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output ecc_pkg::req_t pop_data,
  output logic          empty
);
  import ecc_pkg::*;

  req_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_data;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

/* design/ecc_back.sv */
// ----------------------------------------------------------------------------
// ecc_back: command execution
// Writes obstacle entries, runs the agent and obstacle tests of an agent
// command through the test unit, stores the agent and issues its result.
// ----------------------------------------------------------------------------
module ecc_back #(
  parameter int MAX_AGENTS    = 16,
  parameter int MAX_OBSTACLES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ecc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  ecc_pkg::req_t q_data,
  output logic          pop,
  ecc_rsp_if.source     rsp
);
  import ecc_pkg::*;

  localparam int MAXN = MAX_AGENTS > MAX_OBSTACLES ? MAX_AGENTS : MAX_OBSTACLES;
  localparam int IW   = $clog2(MAXN + 1);
  localparam int ACW  = $clog2(MAX_AGENTS + 1);
  localparam int AIW  = $clog2(MAX_AGENTS);
  localparam int OIW  = MAX_OBSTACLES > 1 ? $clog2(MAX_OBSTACLES) : 1;

  back_state_t     state, state_next;
  logic            phase_obs;
  logic [IW-1:0]   idx, idx_inc, nob;
  logic [ACW-1:0]  cnt, n, n_eff;
  point_t          pos;
  logic            first, hit_a, hit_o;
  logic [1:0]      sticky, sticky_new;
  logic            out_valid;
  rsp_t            out_data;
  logic            obs_we, finish, ovf, last;
  point_t          ag_rd, q_pos;
  obst_t           obs_rd, obs_wr;
  test_req_t       treq;
  test_rsp_t       trsp;
  logic [7:0]      act8;

  assign act8    = 8'(cfg.active);
  assign nob     = (act8 > 8'(MAX_OBSTACLES)) ? IW'(MAX_OBSTACLES) : IW'(act8);
  assign n_eff   = q_data.first_of_step ? '0 : cnt;
  assign idx_inc = idx + 1'b1;
  assign ovf     = n >= ACW'(MAX_AGENTS);
  assign q_pos   = '{x: q_data.pos_x, y: q_data.pos_y, z: q_data.pos_z};
  assign obs_wr  = '{c: q_pos, hx: q_data.obstacle_half_x,
                     hy: q_data.obstacle_half_y, hz: q_data.obstacle_half_z};
  assign sticky_new = (first ? 2'b00 : sticky) | {hit_o, hit_a};
  // last test of the current phase
  assign last = phase_obs ? (idx_inc >= nob) : (idx_inc >= IW'(n));

  ecc_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_AGENTS)) u_agent_ram (
    .clk   (clk),
    .we    (finish && !ovf),
    .waddr (n[AIW-1:0]),
    .wdata (pos),
    .raddr (idx[AIW-1:0]),
    .rdata (ag_rd)
  );

  ecc_ram #(.WIDTH($bits(obst_t)), .DEPTH(MAX_OBSTACLES)) u_obst_ram (
    .clk   (clk),
    .we    (obs_we),
    .waddr (OIW'(q_data.obstacle_slot)),
    .wdata (obs_wr),
    .raddr (idx[OIW-1:0]),
    .rdata (obs_rd)
  );

  always_comb begin
    treq.start = state == ST_START;
    treq.p     = pos;
    if (phase_obs) begin
      treq.q  = obs_rd.c;
      treq.ax = 16'(obs_rd.hx) + 16'(cfg.semi_x);
      treq.ay = 16'(obs_rd.hy) + 16'(cfg.semi_y);
      treq.az = 16'(obs_rd.hz) + 16'(cfg.semi_z);
    end else begin
      treq.q  = ag_rd;
      treq.ax = {cfg.semi_x, 1'b0};
      treq.ay = {cfg.semi_y, 1'b0};
      treq.az = {cfg.semi_z, 1'b0};
    end
  end

  ecc_test u_test (
    .clk  (clk),
    .rst  (rst),
    .treq (treq),
    .trsp (trsp)
  );

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    obs_we     = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_data.req_type == REQ_LOAD) begin
            obs_we = 1'b1;
          end else if (n_eff != '0 || nob != '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ:  state_next = ST_START;
      ST_START: state_next = ST_WAIT;
      ST_WAIT: begin
        if (trsp.done) begin
          if (!last || (!phase_obs && nob != '0)) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      sticky    <= 2'b00;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && q_data.req_type == REQ_AGENT) begin
        pos       <= q_pos;
        first     <= q_data.first_of_step;
        n         <= n_eff;
        idx       <= '0;
        phase_obs <= n_eff == '0;
        hit_a     <= 1'b0;
        hit_o     <= 1'b0;
      end
      if (state == ST_WAIT && trsp.done) begin
        if (phase_obs) begin
          hit_o <= hit_o | trsp.hit;
        end else begin
          hit_a <= hit_a | trsp.hit;
        end
        if (!phase_obs && last) begin
          phase_obs <= 1'b1;
          idx       <= '0;
        end else begin
          idx <= idx_inc;
        end
      end
      if (finish) begin
        out_valid <= 1'b1;
        out_data  <= '{agent_number: ovf ? '1 : NUM_BITS'(n),
                       hits_agent: hit_a, hits_obstacle: hit_o,
                       step_agent_collision: sticky_new[0],
                       step_obstacle_collision: sticky_new[1],
                       agent_overflow: ovf};
        sticky    <= sticky_new;
        cnt       <= ovf ? n : ACW'(n + 1'b1);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
endmodule

/* design/ellipsoid_collision_checker.sv */
// ----------------------------------------------------------------------------
// ellipsoid_collision_checker: agent ellipsoid collision test
// Tests each agent against earlier agents of the step and active obstacles.
// ----------------------------------------------------------------------------
//   channel | dir | handshake      | payload
//   req     | in  | valid / ready  | load or agent item
//   rsp     | out | valid / ready  | hit and sticky flags, one per agent
//   cfg     | in  | cfg_we         | cfg_idx, cfg_data
//
// A load is written to the obstacle table from idle. An agent holds the
// back end while it is tested against n earlier agents of the step and k
// active obstacles: each test runs 19 products through the single 32x32
// multiplier, after a table read and a start, then a compare and a done flag.
// Synchronous reset clears counters, flags and handshakes. A two-entry queue
// keeps intake open while the back end works or waits on a stalled result.
module ellipsoid_collision_checker #(
  parameter int MAX_AGENTS    = 16,
  parameter int MAX_OBSTACLES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ecc_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [ecc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  ecc_req_if.sink                             req,
  ecc_rsp_if.source                           rsp
);
  import ecc_pkg::*;

  cfg_t cfg;
  logic push, full, pop, empty;
  req_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.semi_x <= 15'd256;
      cfg.semi_y <= 15'd256;
      cfg.semi_z <= 15'd256;
      cfg.active <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SEMI_X: cfg.semi_x <= cfg_data;
        REG_SEMI_Y: cfg.semi_y <= cfg_data;
        REG_SEMI_Z: cfg.semi_z <= cfg_data;
        REG_ACTIVE: cfg.active <= cfg_data[ACT_BITS-1:0];
        default: ;
      endcase
    end
  end

  ecc_front #(.MAX_OBSTACLES(MAX_OBSTACLES)) u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ecc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ecc_back #(.MAX_AGENTS(MAX_AGENTS), .MAX_OBSTACLES(MAX_OBSTACLES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (!empty),
    .q_data  (pop_data),
    .pop     (pop),
    .rsp     (rsp)
  );
endmodule

/* design/ecc_checker.sv */
// ----------------------------------------------------------------------------
// ecc_checker: port assertions
// Checks result channel behavior and flag consistency at the top level.
// ----------------------------------------------------------------------------
module ecc_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ecc_pkg::rsp_t rsp_data
);
  import ecc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.agent_overflow |-> rsp_data.agent_number == 4'hF)
    else $error("overflow agent number not all ones");

  a_sticky_a: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.hits_agent |-> rsp_data.step_agent_collision)
    else $error("agent hit without sticky flag");

  a_sticky_o: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.hits_obstacle |-> rsp_data.step_obstacle_collision)
    else $error("obstacle hit without sticky flag");
endmodule

bind ellipsoid_collision_checker ecc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: ellipsoid collision checker testbench
// Drives load and agent transactions with bursty timing, predicts every
// response from a shadow copy of the agent store, obstacle table and
// registers, and checks responses in order under random result stalls.
// ----------------------------------------------------------------------------
module tb;
  import ecc_pkg::*;

  localparam int STORE_DEPTH  = 16;
  localparam int TABLE_DEPTH  = 16;
  localparam int DRAIN_CYCLES = 1500;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 3000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  ecc_req_if req_ch();
  ecc_rsp_if rsp_ch();

  ellipsoid_collision_checker DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  // shadow state
  half_t          semi_x, semi_y, semi_z;
  int             active_cnt;
  point_t         stored_agents [STORE_DEPTH];
  int             stored_cnt;
  obst_t          obstacles [TABLE_DEPTH];
  logic [1:0]     sticky;

  req_t pending_q[$];
  rsp_t expected_rsp_q[$];
  int   errors;
  int   accepted_reqs;
  int   burst_left, gap_left;
  int   stall_mode, stall_timer;
  logic hold_off;
  int   idle_cycles;
  int   center_x, center_y, center_z;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_pending(req_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic void add_expected(rsp_t e);
    expected_rsp_q.insert(expected_rsp_q.size(), e);
  endfunction

  function automatic logic [127:0] sq_dist(pos_t a, pos_t b);
    logic signed [17:0] d;
    logic [127:0] m;
    d = {{2{a[15]}}, a} - {{2{b[15]}}, b};
    if (d < 0) d = -d;
    m = {110'b0, d};
    return m * m;
  endfunction

  // dx^2/A^2 + dy^2/B^2 + dz^2/C^2 < 1 by cross-multiplication
  function automatic bit ellipsoid_overlap(point_t p, point_t q,
                                           logic [16:0] ax, logic [16:0] ay,
                                           logic [16:0] az);
    logic [127:0] a, b, c, lhs, abc;
    a = {111'b0, ax};
    b = {111'b0, ay};
    c = {111'b0, az};
    lhs = sq_dist(p.x, q.x) * (b * c) * (b * c)
        + sq_dist(p.y, q.y) * (a * c) * (a * c)
        + sq_dist(p.z, q.z) * (a * b) * (a * b);
    abc = a * b * c;
    return lhs < abc * abc;
  endfunction

  task automatic apply_item(req_t r);
    point_t p;
    rsp_t   e;
    bit     hit_a, hit_o;
    int     n;
    p = '{x: r.pos_x, y: r.pos_y, z: r.pos_z};
    if (r.req_type == REQ_LOAD) begin
      obstacles[r.obstacle_slot] = '{c: p, hx: r.obstacle_half_x,
                                     hy: r.obstacle_half_y, hz: r.obstacle_half_z};
      return;
    end
    if (r.first_of_step) begin
      stored_cnt = 0;
      sticky = '0;
    end
    hit_a = 1'b0;
    hit_o = 1'b0;
    n = (stored_cnt < STORE_DEPTH) ? stored_cnt : STORE_DEPTH;
    for (int i = 0; i < n; i++)
      if (ellipsoid_overlap(p, stored_agents[i], {semi_x, 1'b0}, {semi_y, 1'b0},
                            {semi_z, 1'b0}))
        hit_a = 1'b1;
    for (int m = 0; m < active_cnt && m < TABLE_DEPTH; m++)
      if (ellipsoid_overlap(p, obstacles[m].c,
                            17'(obstacles[m].hx) + 17'(semi_x),
                            17'(obstacles[m].hy) + 17'(semi_y),
                            17'(obstacles[m].hz) + 17'(semi_z)))
        hit_o = 1'b1;
    e.agent_overflow = (n >= STORE_DEPTH);
    if (e.agent_overflow) begin
      e.agent_number = '1;
    end else begin
      e.agent_number = NUM_BITS'(n);
      stored_agents[n] = p;
      stored_cnt = n + 1;
    end
    if (hit_a) sticky[0] = 1'b1;
    if (hit_o) sticky[1] = 1'b1;
    e.hits_agent = hit_a;
    e.hits_obstacle = hit_o;
    e.step_agent_collision = sticky[0];
    e.step_obstacle_collision = sticky[1];
    add_expected(e);
  endtask

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      accepted_reqs <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_item(pending_q.pop_front());
        accepted_reqs <= accepted_reqs + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and result stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode <= 0;
      stall_timer <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report("unexpected response", 1, 0);
        end else begin
          rsp_t e;
          e = expected_rsp_q.pop_front();
          if (rsp_ch.data.agent_number != e.agent_number)
            report("agent_number", rsp_ch.data.agent_number, e.agent_number);
          if (rsp_ch.data.hits_agent != e.hits_agent)
            report("hits_agent", rsp_ch.data.hits_agent, e.hits_agent);
          if (rsp_ch.data.hits_obstacle != e.hits_obstacle)
            report("hits_obstacle", rsp_ch.data.hits_obstacle, e.hits_obstacle);
          if (rsp_ch.data.step_agent_collision != e.step_agent_collision)
            report("step_agent_collision", rsp_ch.data.step_agent_collision,
                   e.step_agent_collision);
          if (rsp_ch.data.step_obstacle_collision != e.step_obstacle_collision)
            report("step_obstacle_collision", rsp_ch.data.step_obstacle_collision,
                   e.step_obstacle_collision);
          if (rsp_ch.data.agent_overflow != e.agent_overflow)
            report("agent_overflow", rsp_ch.data.agent_overflow, e.agent_overflow);
        end
      end
      if (stall_timer == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_timer <= $urandom_range(16, 200);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      rsp_ch.ready <= !hold_off && (stall_mode == 0 ||
                      (stall_mode == 1 && $urandom_range(0, 1) == 0) ||
                      (stall_mode == 2 && $urandom_range(0, 3) == 0));
    end
  end

  // one long result hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    while (accepted_reqs < 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    case (idx)
      REG_SEMI_X: semi_x = half_t'(value);
      REG_SEMI_Y: semi_y = half_t'(value);
      REG_SEMI_Z: semi_z = half_t'(value);
      REG_ACTIVE: active_cnt = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic req_t make_req(logic kind, int slot, int x, int y, int z,
                                    int hx, int hy, int hz, logic first);
    req_t r;
    r.req_type = kind;
    r.obstacle_slot = SLOT_BITS'(slot);
    r.pos_x = pos_t'(x);
    r.pos_y = pos_t'(y);
    r.pos_z = pos_t'(z);
    r.obstacle_half_x = half_t'(hx);
    r.obstacle_half_y = half_t'(hy);
    r.obstacle_half_z = half_t'(hz);
    r.first_of_step = first;
    return r;
  endfunction

  function automatic int near(int base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic queue_agent(logic first, bit noise);
    int sx, sy, sz;
    sx = 4 * semi_x;
    sy = 4 * semi_y;
    sz = 4 * semi_z;
    if (noise)
      add_pending(make_req(REQ_AGENT, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, first));
    else
      add_pending(make_req(REQ_AGENT, $urandom, near(center_x, sx),
                           near(center_y, sy), near(center_z, sz),
                           $urandom, $urandom, $urandom, first));
  endtask

  initial begin
    int queued, steps_n, act;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    semi_x = 15'd256;
    semi_y = 15'd256;
    semi_z = 15'd256;
    active_cnt = 0;
    stored_cnt = 0;
    sticky = '0;
    foreach (obstacles[i]) obstacles[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: fill the whole table, then agents at the origin and the corners
    set_reg(REG_ACTIVE, TABLE_DEPTH);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0)
        add_pending(make_req(REQ_LOAD, i, 32767, 32767, 32767,
                             32767, 32767, 32767, 1'b1));
      else if (i == 1)
        add_pending(make_req(REQ_LOAD, i, -32768, -32768, -32768, 0, 0, 0, 1'b0));
      else
        add_pending(make_req(REQ_LOAD, i, near(0, 2048), near(0, 2048),
                             near(0, 2048), $urandom_range(0, 1024),
                             $urandom_range(0, 1024), $urandom_range(0, 1024),
                             $urandom));
    end
    add_pending(make_req(REQ_AGENT, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    add_pending(make_req(REQ_AGENT, 15, 0, 0, 0, 32767, 32767, 32767, 1'b0));
    add_pending(make_req(REQ_AGENT, 0, 32767, 32767, 32767, 0, 0, 0, 1'b0));
    add_pending(make_req(REQ_AGENT, 0, -32768, -32768, -32768, 0, 0, 0, 1'b0));
    add_pending(make_req(REQ_AGENT, 7, 1, -1, 0, 12345, 6789, 321, 1'b1));
    add_pending(make_req(REQ_AGENT, 0, -32768, 32767, 0, 0, 0, 0, 1'b0));
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        1: begin
          set_reg(REG_SEMI_X, 32767); set_reg(REG_SEMI_Y, 32767);
          set_reg(REG_SEMI_Z, 32767); set_reg(REG_ACTIVE, TABLE_DEPTH);
        end
        2: begin
          set_reg(REG_SEMI_X, 1); set_reg(REG_SEMI_Y, 1);
          set_reg(REG_SEMI_Z, 1); set_reg(REG_ACTIVE, 0);
        end
        default: begin
          set_reg(REG_SEMI_X, $urandom_range(32, 2048));
          set_reg(REG_SEMI_Y, $urandom_range(32, 2048));
          set_reg(REG_SEMI_Z, $urandom_range(32, 2048));
          act = (ph == 5) ? TABLE_DEPTH : $urandom_range(0, 4);
          set_reg(REG_ACTIVE, act);
        end
      endcase
      queued = 0;
      while (queued < 200) begin
        center_x = $urandom_range(0, 65535) - 32768;
        center_y = $urandom_range(0, 65535) - 32768;
        center_z = $urandom_range(0, 65535) - 32768;
        repeat ($urandom_range(0, 2)) begin
          add_pending(make_req(REQ_LOAD, $urandom, near(center_x, 4 * semi_x),
                               near(center_y, 4 * semi_y), near(center_z, 4 * semi_z),
                               ($urandom_range(0, 7) == 0) ? $urandom
                                 : $urandom_range(0, 2 * semi_x),
                               ($urandom_range(0, 7) == 0) ? $urandom
                                 : $urandom_range(0, 2 * semi_y),
                               ($urandom_range(0, 7) == 0) ? $urandom
                                 : $urandom_range(0, 2 * semi_z),
                               $urandom));
          queued++;
        end
        // a rare long step overruns the agent store
        if (active_cnt <= 2 && $urandom_range(0, 39) == 0)
          steps_n = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
        else
          steps_n = $urandom_range(1, 6);
        for (int k = 0; k < steps_n; k++) begin
          queue_agent(k == 0 || $urandom_range(0, 29) == 0, $urandom_range(0, 9) == 0);
          queued++;
        end
      end
      wait_idle();
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
